### src/keyed_width_permutation_assert.svh
// ---------------------------------------------------------------------------
// keyed_width_permutation_assert.svh
// assertion macros shared by the checker of the keyed width permutation
// ---------------------------------------------------------------------------
`ifndef KEYED_WIDTH_PERMUTATION_ASSERT_SVH
`define KEYED_WIDTH_PERMUTATION_ASSERT_SVH

// same-cycle implication, held off while in reset
`define KWP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while in reset
`define KWP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// plain check at every edge, reset included
`define KWP_ASSERT_ALWAYS(lbl, clk, expr, msg) \
    lbl: assert property (@(posedge clk) (expr)) \
        else $error(msg);

`endif

### src/kwp_pkg.sv
// ---------------------------------------------------------------------------
// kwp_pkg
// types, constants and substitution boxes of the keyed width permutation
// ---------------------------------------------------------------------------
`default_nettype none

package kwp_pkg;

    // default configuration of the top level
    localparam int ROUNDS_DEF    = 7;
    localparam int MAX_WIDTH_DEF = 32;

    // widths of the configuration bus and derived settings
    localparam int CFG_DATA_W = 32;
    localparam int CFG_LEN_W  = 6;
    localparam int APB_ADDR_W = 3;

    // reset values of the registers
    localparam logic [CFG_LEN_W-1:0]  WIDTH_BITS_RST = 6'd32;
    localparam logic [CFG_DATA_W-1:0] ROUND_KEY_RST  = 32'h0000_0000;

    // smallest supported width and the rotate distance of a round
    localparam logic [CFG_LEN_W-1:0] MIN_LEN  = 6'd8;
    localparam logic [CFG_LEN_W-1:0] ROT_DIST = 6'd5;

    // register word index
    typedef enum logic {
        REG_WIDTH_BITS = 1'b0,
        REG_ROUND_KEY  = 1'b1
    } kwp_reg_t;

    // settings shared by every round cell
    typedef struct packed {
        logic [CFG_LEN_W-1:0]  len;
        logic [CFG_LEN_W-1:0]  shift;
        logic [CFG_DATA_W-1:0] fmask;
        logic [CFG_DATA_W-1:0] hmask;
        logic [CFG_DATA_W-1:0] key;
    } kwp_cfg_t;

    // four fixed 4-bit boxes, one per nibble of the low half-field
    localparam logic [3:0] SBOX [4][16] = '{
        '{4'h4, 4'hA, 4'h9, 4'h2, 4'hD, 4'h8, 4'h0, 4'hE,
          4'h6, 4'hB, 4'h1, 4'hC, 4'h7, 4'hF, 4'h5, 4'h3},
        '{4'hE, 4'hB, 4'h4, 4'hC, 4'h6, 4'hD, 4'hF, 4'hA,
          4'h2, 4'h3, 4'h8, 4'h1, 4'h0, 4'h7, 4'h5, 4'h9},
        '{4'h5, 4'h8, 4'h1, 4'hD, 4'hA, 4'h3, 4'h4, 4'h2,
          4'hE, 4'hF, 4'hC, 4'h7, 4'h6, 4'h0, 4'h9, 4'hB},
        '{4'h7, 4'hD, 4'hA, 4'h1, 4'h0, 4'h8, 4'h9, 4'hF,
          4'hE, 4'h4, 4'h6, 4'hC, 4'hB, 4'h2, 4'h5, 4'h3}
    };

    function automatic logic [3:0] sbox_sub(input logic [1:0] box, input logic [3:0] nib);
        return SBOX[box][nib];
    endfunction

endpackage

`default_nettype wire

### src/kwp_cfg_regs.sv
// ---------------------------------------------------------------------------
// kwp_cfg_regs
// register file on the configuration port and the derived round settings
// ---------------------------------------------------------------------------
`default_nettype none

module kwp_cfg_regs #(
    parameter int MAX_WIDTH = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [kwp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [kwp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [kwp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output kwp_pkg::kwp_cfg_t                   cfg
);
    import kwp_pkg::*;

    localparam logic [CFG_LEN_W-1:0] MAX_LEN = CFG_LEN_W'(MAX_WIDTH);

    logic [CFG_LEN_W-1:0]  width_bits_reg;
    logic [CFG_DATA_W-1:0] round_key_reg;
    logic                  wr_en;
    kwp_reg_t              reg_sel;
    logic [CFG_LEN_W-1:0]  len;
    logic [CFG_LEN_W-1:0]  half;
    logic [CFG_DATA_W-1:0] fmask;
    logic [CFG_DATA_W-1:0] hmask;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = kwp_reg_t'(paddr[2]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_bits_reg <= WIDTH_BITS_RST;
            round_key_reg  <= ROUND_KEY_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_WIDTH_BITS: width_bits_reg <= pwdata[CFG_LEN_W-1:0];
                REG_ROUND_KEY:  round_key_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_sel)
            REG_WIDTH_BITS: prdata = {{(CFG_DATA_W-CFG_LEN_W){1'b0}}, width_bits_reg};
            REG_ROUND_KEY:  prdata = round_key_reg;
            default:        prdata = '0;
        endcase
    end

    // width clamped to the supported range, half-field of four bits per byte
    always_comb
    begin
        if (width_bits_reg < MIN_LEN)
            len = MIN_LEN;
        else if (width_bits_reg > MAX_LEN)
            len = MAX_LEN;
        else
            len = width_bits_reg;
        half = {1'b0, len[CFG_LEN_W-1:3], 2'b00};
    end

    // field and half-field masks
    always_comb
    begin
        for (int i = 0; i < CFG_DATA_W; i++)
        begin
            fmask[i] = (CFG_LEN_W'(i) < len);
            hmask[i] = (CFG_LEN_W'(i) < half);
        end
    end

    assign cfg.len   = len;
    assign cfg.shift = len - half;
    assign cfg.fmask = fmask;
    assign cfg.hmask = hmask;
    assign cfg.key   = round_key_reg & fmask;

endmodule

`default_nettype wire

### src/kwp_round_cell.sv
// ---------------------------------------------------------------------------
// kwp_round_cell
// one feistel round followed by a pipeline register with its own valid
// ---------------------------------------------------------------------------
`default_nettype none

module kwp_round_cell #(
    parameter int MAX_WIDTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  kwp_pkg::kwp_cfg_t         cfg,
    input  wire logic                 up_valid,
    input  wire logic [MAX_WIDTH-1:0] up_data,
    output logic                      up_ready,
    output logic                      dn_valid,
    output logic      [MAX_WIDTH-1:0] dn_data,
    input  wire logic                 dn_ready
);
    import kwp_pkg::*;

    logic                 valid_reg;
    logic [MAX_WIDTH-1:0] data_reg;
    logic [MAX_WIDTH-1:0] data_next;
    logic [MAX_WIDTH-1:0] fmask;
    logic [MAX_WIDTH-1:0] hmask;
    logic [MAX_WIDTH-1:0] lo;
    logic [MAX_WIDTH-1:0] hi;
    logic [MAX_WIDTH-1:0] mid;
    logic [MAX_WIDTH-1:0] s_raw;
    logic [MAX_WIDTH-1:0] mixed;

    assign fmask = cfg.fmask[MAX_WIDTH-1:0];
    assign hmask = cfg.hmask[MAX_WIDTH-1:0];

    // split into low field, high field and untouched middle
    assign lo  = up_data & hmask;
    assign hi  = (up_data >> cfg.shift) & hmask;
    assign mid = up_data & ~(hmask | (hmask << cfg.shift));

    // substitution of the low nibbles, one box per nibble
    for (genvar b = 0; b < MAX_WIDTH; b++)
    begin : g_sub
        if (b < 16 && (4 * (b / 4) + 3) < MAX_WIDTH)
        begin : g_box
            logic [3:0] nib_out;
            assign nib_out  = sbox_sub(2'(b / 4), lo[4 * (b / 4) +: 4]);
            assign s_raw[b] = nib_out[b % 4];
        end
        else
        begin : g_zero
            assign s_raw[b] = 1'b0;
        end
    end

    // feistel swap, key mix and rotate within the width
    always_comb
    begin
        mixed     = ((((s_raw & hmask) ^ hi) << cfg.shift) | hi | mid) ^ cfg.key[MAX_WIDTH-1:0];
        mixed     = mixed & fmask;
        data_next = ((mixed << ROT_DIST) | (mixed >> (cfg.len - ROT_DIST))) & fmask;
    end

    assign up_ready = ~valid_reg | dn_ready;

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

### src/keyed_width_permutation.sv
// ---------------------------------------------------------------------------
// keyed_width_permutation
// keyed feistel bijection on a value of configurable width, one cell a round
// ---------------------------------------------------------------------------
// pipeline: an input transfer reaches value_out through the cells in order, one registered cell per round
// throughput: one transfer per cycle while not stalled; each cell holds one round and its register
// a stalled output backs up the cells one by one, input stall once all are full
// reset: all cell valids cleared, width_bits back to 32, round_key to zero
`default_nettype none

module keyed_width_permutation #(
    parameter int ROUNDS    = kwp_pkg::ROUNDS_DEF,
    parameter int MAX_WIDTH = kwp_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [kwp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [kwp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [kwp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [MAX_WIDTH-1:0]           value_in,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [MAX_WIDTH-1:0]           value_out
);
    import kwp_pkg::*;

    kwp_cfg_t             cfg;
    logic                 chain_valid [ROUNDS+1];
    logic                 chain_ready [ROUNDS+1];
    logic [MAX_WIDTH-1:0] chain_data  [ROUNDS+1];

    // configuration registers
    kwp_cfg_regs #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // chain entry, bits above the width dropped
    assign chain_valid[0] = in_valid;
    assign chain_data[0]  = value_in & cfg.fmask[MAX_WIDTH-1:0];
    assign in_stall       = ~chain_ready[0];

    // row of round cells
    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        kwp_round_cell #(
            .MAX_WIDTH (MAX_WIDTH)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg      (cfg),
            .up_valid (chain_valid[r]),
            .up_data  (chain_data[r]),
            .up_ready (chain_ready[r]),
            .dn_valid (chain_valid[r+1]),
            .dn_data  (chain_data[r+1]),
            .dn_ready (chain_ready[r+1])
        );
    end

    // chain exit
    assign chain_ready[ROUNDS] = ~out_stall;
    assign out_valid           = chain_valid[ROUNDS];
    assign value_out           = chain_data[ROUNDS];

endmodule

`default_nettype wire

### src/kwp_checker.sv
// ---------------------------------------------------------------------------
// kwp_checker
// port-level checks of the keyed width permutation, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "keyed_width_permutation_assert.svh"

module kwp_checker #(
    parameter int MAX_WIDTH = 32
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_stall,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic [MAX_WIDTH-1:0] value_out
);

    logic out_held;

    // output transfer offered but held back
    assign out_held = out_valid && out_stall;

    // held output transfer stays offered
    `KWP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid, "out_valid dropped")

    // held output payload does not move
    `KWP_ASSERT_NEXT(a_out_stable, clk, rst_n, out_held, $stable(value_out), "value_out moved")

    // input stalls only when the whole row is full and the output is blocked
    `KWP_ASSERT_IMP(a_stall_full, clk, rst_n, in_stall, out_held, "input stalled with room")

    // nothing offered at the output during reset
    `KWP_ASSERT_ALWAYS(a_reset_idle, clk, rst_n || !out_valid, "out_valid high in reset")

endmodule

bind keyed_width_permutation kwp_checker #(
    .MAX_WIDTH (MAX_WIDTH)
) u_kwp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value_out (value_out)
);

`default_nettype wire
